// ===== rtl/acfb_pkg.sv =====
package acfb_pkg;

    typedef logic [7:0] t_byte;

    // command codes as carried by the func field
    typedef enum logic [2:0] {
        FN_MONITOR    = 3'd0,
        FN_RESET      = 3'd1,
        FN_TIME       = 3'd2,
        FN_PRESET     = 3'd3,
        FN_RATE       = 3'd4,
        FN_MODE       = 3'd5,
        FN_POS_TRACK  = 3'd6,
        FN_PROG_TRACK = 3'd7
    } t_func;

    localparam t_byte STX_BYTE = 8'h02;
    localparam t_byte ETX_BYTE = 8'h03;

    // rate sent in place of both velocities on the track commands when fitting is requested
    localparam logic [31:0] FIT_RATE   = 32'd0 - 32'd11111000;
    localparam t_byte       POWER_CTRL = 8'd128;
    localparam t_byte       IDLE_CTRL  = 8'd1;

    // bit positions in the options field
    localparam int OPT_POWER = 0;
    localparam int OPT_FIT   = 1;
    localparam int OPT_CLEAR = 2;

    localparam int FRAME_MAX   = 31;
    localparam int HEAD_BYTES  = 4;
    localparam int PAY_BYTES   = 24;
    localparam int BODY_BYTES  = HEAD_BYTES + PAY_BYTES;
    localparam int IDX_W       = $clog2(FRAME_MAX + 1);
    localparam int QUEUE_DEPTH = 2;

    // total frame lengths per command group
    localparam logic [IDX_W-1:0] LEN_BARE  = IDX_W'(7);
    localparam logic [IDX_W-1:0] LEN_PAIR  = IDX_W'(15);
    localparam logic [IDX_W-1:0] LEN_MODE  = IDX_W'(11);
    localparam logic [IDX_W-1:0] LEN_POS   = IDX_W'(25);
    localparam logic [IDX_W-1:0] LEN_PROG  = IDX_W'(31);

    // one classified request: header and payload bytes plus total length
    typedef struct packed {
        logic [BODY_BYTES-1:0][7:0] body;
        logic [IDX_W-1:0]           len;
    } t_frame;

    function automatic t_byte cmd_letter(input t_func f);
        t_byte l;
        case (f)
            FN_MONITOR:    l = "q";
            FN_RESET:      l = "X";
            FN_TIME:       l = "T";
            FN_PRESET:     l = "P";
            FN_RATE:       l = "R";
            FN_MODE:       l = "M";
            FN_POS_TRACK:  l = "o";
            FN_PROG_TRACK: l = "O";
            default:       l = "q";
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/acfb_if.sv =====
interface acfb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] azimuth;
    logic [31:0] elevation;
    logic [31:0] az_rate;
    logic [31:0] el_rate;
    logic [31:0] time_of_day;
    logic [8:0]  day_of_year;
    logic [15:0] year_number;
    logic [7:0]  az_mode;
    logic [7:0]  el_mode;
    logic [2:0]  options;

    modport source (
        output valid, func, azimuth, elevation, az_rate, el_rate, time_of_day,
               day_of_year, year_number, az_mode, el_mode, options,
        input  ready
    );
    modport sink (
        input  valid, func, azimuth, elevation, az_rate, el_rate, time_of_day,
               day_of_year, year_number, az_mode, el_mode, options,
        output ready
    );
endinterface

interface acfb_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== rtl/acfb_front.sv =====
module acfb_front (
    acfb_req_if.sink           i_req,
    input  logic               i_full,
    output logic               o_push,
    output acfb_pkg::t_frame   o_frame
);
    import acfb_pkg::*;

    logic [8*PAY_BYTES-1:0] pay;
    logic [IDX_W-1:0]       len;
    logic [31:0]            azr_eff;
    logic [31:0]            elr_eff;
    logic [15:0]            doy16;
    logic [15:0]            clr16;
    t_byte                  ctrl;
    t_func                  fn;

    assign fn      = t_func'(i_req.func);
    assign azr_eff = i_req.options[OPT_FIT] ? FIT_RATE : i_req.az_rate;
    assign elr_eff = i_req.options[OPT_FIT] ? FIT_RATE : i_req.el_rate;
    assign doy16   = {7'd0, i_req.day_of_year};
    assign clr16   = i_req.options[OPT_CLEAR] ? 16'd0 : 16'd1;
    assign ctrl    = i_req.options[OPT_POWER] ? POWER_CTRL : IDLE_CTRL;

    // payload packed with the first byte on the wire in the low bits
    always_comb begin
        case (fn)
            FN_TIME: begin
                pay = {128'd0, i_req.year_number, doy16, i_req.time_of_day};
                len = LEN_PAIR;
            end
            FN_PRESET: begin
                pay = {128'd0, i_req.elevation, i_req.azimuth};
                len = LEN_PAIR;
            end
            FN_RATE: begin
                pay = {128'd0, i_req.el_rate, i_req.az_rate};
                len = LEN_PAIR;
            end
            FN_MODE: begin
                pay = {160'd0, ctrl, 8'd1, i_req.el_mode, i_req.az_mode};
                len = LEN_MODE;
            end
            FN_POS_TRACK: begin
                pay = {48'd0, elr_eff, i_req.elevation, azr_eff, i_req.azimuth, 16'd0};
                len = LEN_POS;
            end
            FN_PROG_TRACK: begin
                pay = {elr_eff, i_req.elevation, azr_eff, i_req.azimuth,
                       doy16, i_req.time_of_day, clr16};
                len = LEN_PROG;
            end
            default: begin
                pay = '0;
                len = LEN_BARE;
            end
        endcase
    end

    assign o_frame.body = {pay, 8'h00, {{(8-IDX_W){1'b0}}, len}, cmd_letter(fn), STX_BYTE};
    assign o_frame.len  = len;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

endmodule

// ===== rtl/acfb_queue.sv =====
module acfb_queue #(
    parameter int P_DEPTH = acfb_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  acfb_pkg::t_frame               i_frame,
    input  logic                           i_pop,
    output logic                           o_valid,
    output logic                           o_full,
    output logic [$clog2(P_DEPTH+1)-1:0]   o_level,
    output acfb_pkg::t_frame               o_frame
);
    import acfb_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_frame             r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    assign o_frame = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(P_DEPTH));
    assign o_level = r_cnt;

endmodule

// ===== rtl/acfb_back.sv =====
module acfb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  acfb_pkg::t_frame   i_frame,
    output logic               o_pop,
    acfb_frm_if.source         o_frm
);
    import acfb_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_sum;
    logic             r_valid;
    t_byte            r_byte;
    logic             r_last;

    logic             load;
    logic             emit;
    logic             is_last;
    logic             in_sum;
    t_byte            cur;

    assign load    = !r_valid || o_frm.ready;
    assign emit    = i_valid && load;
    assign is_last = (r_idx == i_frame.len - 1'b1);
    // identifier through end of payload count in the checksum
    assign in_sum  = (r_idx != '0) && (r_idx < i_frame.len - IDX_W'(3));

    always_comb begin
        if (is_last) begin
            cur = ETX_BYTE;
        end else if (r_idx == i_frame.len - IDX_W'(2)) begin
            cur = r_sum[15:8];
        end else if (r_idx == i_frame.len - IDX_W'(3)) begin
            cur = r_sum[7:0];
        end else if (r_idx < IDX_W'(BODY_BYTES)) begin
            cur = i_frame.body[r_idx];
        end else begin
            cur = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? '0 : r_idx + 1'b1;
            if (is_last) begin
                r_sum <= '0;
            end else if (in_sum) begin
                r_sum <= r_sum + {8'd0, cur};
            end
        end else if (o_frm.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= cur;
            r_last <= is_last;
        end
    end

    assign o_pop           = emit && is_last;
    assign o_frm.valid     = r_valid;
    assign o_frm.out_byte  = r_byte;
    assign o_frm.last_byte = r_last;

endmodule

// ===== rtl/antenna_command_frame_builder_core.sv =====
// antenna command frame builder: one request word on i_req becomes a serial
// frame of 7 to 31 byte words on o_frm (STX, command letter, 16-bit length,
// little-endian payload, 16-bit byte sum from the letter to the payload end,
// ETX), with last_byte marking the ETX word. the front end classifies the
// command and lays out header and payload combinationally and parks the result
// in a small frame queue (P_QUEUE_DEPTH entries); i_req.ready is high while
// that queue has room. the back end reads the queue head and sends one byte
// word per cycle while o_frm.ready allows, through a registered output stage,
// adding the checksum on the fly, and the next frame follows straight after
// with no gap. request acceptance is therefore bounded by the single byte
// lane of the output stage. no configuration, no reset sweep
module antenna_command_frame_builder_core #(
    parameter int P_QUEUE_DEPTH = acfb_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acfb_req_if.sink    i_req,
    acfb_frm_if.source  o_frm
);
    import acfb_pkg::*;

    // frame descriptor path between front end and back end
    t_frame                             w_push_frame;
    t_frame                             w_head_frame;
    logic                               w_push;
    logic                               w_pop;
    logic                               w_full;
    logic                               w_head_valid;
    logic [$clog2(P_QUEUE_DEPTH+1)-1:0] w_level;

    // classify the request and lay out header plus payload
    acfb_front u_front (
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_frame (w_push_frame)
    );

    // decouples request acceptance from byte streaming
    acfb_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_full  (w_full),
        .o_level (w_level),
        .o_frame (w_head_frame)
    );

    // serialise the head frame, checksum and ETX appended here
    acfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_head_valid),
        .i_frame (w_head_frame),
        .o_pop   (w_pop),
        .o_frm   (o_frm)
    );

    // a frame is only released from the queue when one is held
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("frame queue popped while empty");

    // queue occupancy never exceeds its depth
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= ($clog2(P_QUEUE_DEPTH+1))'(P_QUEUE_DEPTH))
        else $error("frame queue level out of range");

    // the closing word of every frame carries ETX
    a_last_is_etx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frm.valid && o_frm.last_byte) |-> (o_frm.out_byte == ETX_BYTE))
        else $error("frame end word is not ETX");

    // popping the head ends a frame: the word loaded that cycle is the last
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_frm.valid && o_frm.last_byte))
        else $error("frame released without its end word");

endmodule

// ===== tb/antenna_command_frame_builder_core_tb.sv =====
module antenna_command_frame_builder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import acfb_pkg::*;

    // one command request as driven on the request channel
    typedef struct packed {
        t_func       func;
        logic [31:0] az;
        logic [31:0] el;
        logic [31:0] azr;
        logic [31:0] elr;
        logic [31:0] tod;
        logic [8:0]  doy;
        logic [15:0] yr;
        logic [7:0]  azm;
        logic [7:0]  elm;
        logic [2:0]  opt;
    } req_t;

    // one frame word still to come out of the block
    typedef struct {
        t_byte data;
        logic  is_last;
    } frame_word_t;

    // directed row: a request plus, for the frames that are obvious by hand,
    // the whole frame typed in (n_known bytes, 0 means use the predictor)
    typedef struct {
        req_t             req;
        int               n_known;
        logic [0:10][7:0] known;
    } dir_row_t;

    // identifier letters indexed by command code
    localparam logic [0:7][7:0] CMD_CHARS = "qXTPRMoO";

    localparam int N_RANDOM     = 200;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT_WORD = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    acfb_req_if req_bus ();
    acfb_frm_if frm_bus ();

    frame_word_t frame_exp_q[$];   // frame words awaited, oldest first
    t_byte       frame_buf[$];     // scratch for the frame under construction
    dir_row_t    dir_rows[$];
    int          err_cnt   = 0;
    int unsigned calm_left = 0;    // requests still to send without gaps

    antenna_command_frame_builder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_frm   (frm_bus)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (err_cnt < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        err_cnt++;
    endtask

    // mostly back to back, sometimes a short pause, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // 32-bit field value with the extremes well represented
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t mk_req(input t_func f, input logic [31:0] az, input logic [31:0] el,
                                    input logic [31:0] azr, input logic [31:0] elr,
                                    input logic [31:0] tod, input logic [8:0] doy,
                                    input logic [15:0] yr, input logic [7:0] azm,
                                    input logic [7:0] elm, input logic [2:0] opt);
        req_t r;
        r.func = f;
        r.az   = az;
        r.el   = el;
        r.azr  = azr;
        r.elr  = elr;
        r.tod  = tod;
        r.doy  = doy;
        r.yr   = yr;
        r.azm  = azm;
        r.elm  = elm;
        r.opt  = opt;
        return r;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.func = t_func'($urandom_range(0, 7));
        r.az   = pick32();
        r.el   = pick32();
        r.azr  = pick32();
        r.elr  = pick32();
        r.tod  = pick32();
        // day of year beyond 366 still fits the field, so it gets sent too
        if ($urandom_range(0, 9) == 0) begin
            r.doy = 9'($urandom_range(367, 511));
        end else begin
            r.doy = 9'($urandom_range(0, 366));
        end
        r.yr  = 16'(pick32());
        r.azm = 8'(pick32());
        r.elm = 8'(pick32());
        r.opt = 3'($urandom_range(0, 7));
        return r;
    endfunction

    task automatic add_row(input req_t r, input int n = 0, input logic [0:10][7:0] k = '0);
        dir_row_t row;
        row.req     = r;
        row.n_known = n;
        row.known   = k;
        dir_rows.push_back(row);
    endtask

    // little-endian append of the low n bytes
    function automatic void add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            frame_buf.push_back(v[8*i +: 8]);
        end
    endfunction

    // lays out the whole frame for one request and queues its words
    function automatic void build_frame_words(input req_t r);
        logic [31:0] azr;
        logic [31:0] elr;
        logic [15:0] flen;
        logic [15:0] csum;
        frame_word_t w;
        azr = r.azr;
        elr = r.elr;
        // fitted rates replace both velocities, but only on the track commands
        if (r.opt[OPT_FIT] && (r.func == FN_POS_TRACK || r.func == FN_PROG_TRACK)) begin
            azr = FIT_RATE;
            elr = FIT_RATE;
        end
        frame_buf.delete();
        frame_buf.push_back(STX_BYTE);
        frame_buf.push_back(CMD_CHARS[r.func]);
        add_le(32'h0, 2);   // length, filled in once the payload is known
        case (r.func)
            FN_TIME: begin
                add_le(r.tod, 4);
                add_le(32'(r.doy), 2);
                add_le(32'(r.yr), 2);
            end
            FN_PRESET: begin
                add_le(r.az, 4);
                add_le(r.el, 4);
            end
            FN_RATE: begin
                add_le(r.azr, 4);
                add_le(r.elr, 4);
            end
            FN_MODE: begin
                frame_buf.push_back(r.azm);
                frame_buf.push_back(r.elm);
                frame_buf.push_back(8'd1);
                frame_buf.push_back(r.opt[OPT_POWER] ? POWER_CTRL : IDLE_CTRL);
            end
            FN_POS_TRACK: begin
                add_le(32'h0, 2);   // spare bytes, always zero
                add_le(r.az, 4);
                add_le(azr, 4);
                add_le(r.el, 4);
                add_le(elr, 4);
            end
            FN_PROG_TRACK: begin
                add_le(r.opt[OPT_CLEAR] ? 32'd0 : 32'd1, 2);
                add_le(r.tod, 4);
                add_le(32'(r.doy), 2);
                add_le(r.az, 4);
                add_le(azr, 4);
                add_le(r.el, 4);
                add_le(elr, 4);
            end
            default: ;
        endcase
        // payload plus checksum and ETX still to come
        flen = 16'(frame_buf.size() + 3);
        frame_buf[2] = flen[7:0];
        frame_buf[3] = flen[15:8];
        csum = '0;
        for (int i = 1; i < frame_buf.size(); i++) begin
            csum = csum + {8'h00, frame_buf[i]};
        end
        add_le(32'(csum), 2);
        frame_buf.push_back(ETX_BYTE);
        foreach (frame_buf[i]) begin
            w.data    = frame_buf[i];
            w.is_last = (i == frame_buf.size() - 1);
            frame_exp_q.push_back(w);
        end
    endfunction

    task automatic queue_known(input int n, input logic [0:10][7:0] k);
        frame_word_t w;
        for (int i = 0; i < n; i++) begin
            w.data    = k[i];
            w.is_last = (i == n - 1);
            frame_exp_q.push_back(w);
        end
    endtask

    // hold off before the next request, or run back to back during a calm spell
    task automatic pace();
        int unsigned g;
        if (calm_left > 0) begin
            g = 0;
            calm_left--;
        end else begin
            g = gap_len();
            if ($urandom_range(0, 24) == 0) calm_left = 12;
        end
        if (g > 0) begin
            req_bus.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // present one request and wait for the block to take it
    task automatic offer(input req_t r);
        req_bus.valid       <= 1'b1;
        req_bus.func        <= r.func;
        req_bus.azimuth     <= r.az;
        req_bus.elevation   <= r.el;
        req_bus.az_rate     <= r.azr;
        req_bus.el_rate     <= r.elr;
        req_bus.time_of_day <= r.tod;
        req_bus.day_of_year <= r.doy;
        req_bus.year_number <= r.yr;
        req_bus.az_mode     <= r.azm;
        req_bus.el_mode     <= r.elm;
        req_bus.options     <= r.opt;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic take_word(input t_byte data, input logic is_last);
        frame_word_t w;
        if (frame_exp_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected word %02h last %b", data, is_last));
        end else begin
            w = frame_exp_q.pop_front();
            if (data !== w.data) begin
                flag_mismatch($sformatf("out_byte %02h, wanted %02h", data, w.data));
            end
            if (is_last !== w.is_last) begin
                flag_mismatch($sformatf("last_byte %b, wanted %b (byte %02h)",
                                        is_last, w.is_last, w.data));
            end
        end
    endtask

    // request side: directed rows first, then random requests
    initial begin : req_source
        req_bus.valid       <= 1'b0;
        req_bus.func        <= FN_MONITOR;
        req_bus.azimuth     <= '0;
        req_bus.elevation   <= '0;
        req_bus.az_rate     <= '0;
        req_bus.el_rate     <= '0;
        req_bus.time_of_day <= '0;
        req_bus.day_of_year <= '0;
        req_bus.year_number <= '0;
        req_bus.az_mode     <= '0;
        req_bus.el_mode     <= '0;
        req_bus.options     <= '0;

        // bare frames, every other field must be ignored
        add_row(mk_req(FN_MONITOR, '1, '1, '1, '1, '1, '1, '1, '1, '1, 3'd7), 7,
                {8'h02, 8'h71, 8'h07, 8'h00, 8'h78, 8'h00, 8'h03, 32'h0});
        add_row(mk_req(FN_RESET, '0, '0, '0, '0, '0, '0, '0, '0, '0, 3'd0), 7,
                {8'h02, 8'h58, 8'h07, 8'h00, 8'h5F, 8'h00, 8'h03, 32'h0});
        // mode selection without and with drive power, checksum carrying into the high byte
        add_row(mk_req(FN_MODE, '0, '0, '0, '0, '0, '0, '0, 8'h00, 8'h00, 3'd0), 11,
                {8'h02, 8'h4D, 8'h0B, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h5A, 8'h00, 8'h03});
        add_row(mk_req(FN_MODE, '0, '0, '0, '0, '0, '0, '0, 8'hFF, 8'hFF, 3'd1), 11,
                {8'h02, 8'h4D, 8'h0B, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'hD7, 8'h02, 8'h03});
        add_row(mk_req(FN_MODE, '1, '1, '1, '1, '1, '1, '1, 8'h5A, 8'hA5, 3'd6));
        // time transfer across the field extremes, day beyond the calendar too
        add_row(mk_req(FN_TIME, '0, '0, '0, '0, 32'h7FFF_FFFF, 9'd366, 16'hFFFF, '0, '0, 3'd0));
        add_row(mk_req(FN_TIME, '1, '1, '1, '1, 32'h8000_0000, 9'd0, 16'h0000, '1, '1, 3'd7));
        add_row(mk_req(FN_TIME, '0, '0, '0, '0, 32'hFFFF_FFFF, 9'd511, 16'h1234, '0, '0, 3'd2));
        add_row(mk_req(FN_PRESET, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1, '1, '1, '1, '1,
                       3'd0));
        add_row(mk_req(FN_PRESET, 32'hFFFF_FFFF, 32'h0, '0, '0, '0, '0, '0, '0, '0, 3'd7));
        // rate command keeps its own velocities even with fit requested
        add_row(mk_req(FN_RATE, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0, '0, '0,
                       3'd2));
        add_row(mk_req(FN_RATE, '1, '1, 32'h0000_0001, 32'hFFFF_FFFF, '1, '1, '1, '1, '1,
                       3'd0));
        // position track, plain and with fitted rates
        add_row(mk_req(FN_POS_TRACK, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0,
                       '0, '0, '0, '0, '0, 3'd0));
        add_row(mk_req(FN_POS_TRACK, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0,
                       '0, '0, '0, '0, '0, 3'd2));
        add_row(mk_req(FN_POS_TRACK, '1, '1, '1, '1, '1, '1, '1, '1, '1, 3'd7));
        // program track: keep table, clear table, fit, both, largest frame
        add_row(mk_req(FN_PROG_TRACK, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                       32'hF0F0_F0F0, 32'h0001_5180, 9'd123, '0, '0, '0, 3'd0));
        add_row(mk_req(FN_PROG_TRACK, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                       32'hF0F0_F0F0, 32'h0001_5180, 9'd123, '0, '0, '0, 3'd4));
        add_row(mk_req(FN_PROG_TRACK, '1, '1, '1, '1, '1, 9'd511, '1, '1, '1, 3'd6));
        add_row(mk_req(FN_PROG_TRACK, '0, '0, '0, '0, '0, 9'd0, '0, '0, '0, 3'd2));
        add_row(mk_req(FN_PROG_TRACK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 9'd366, '0, '0, '0, 3'd3));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            pace();
            offer(dir_rows[i].req);
            if (dir_rows[i].n_known > 0) begin
                queue_known(dir_rows[i].n_known, dir_rows[i].known);
            end else begin
                build_frame_words(dir_rows[i].req);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            req_t r;
            r = rand_req();
            pace();
            offer(r);
            build_frame_words(r);
        end
        req_bus.valid <= 1'b0;

        // let the last frames drain, then a short margin for stray words
        while (frame_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // frame side: random back-pressure, one long hold-off part way through
    initial begin : frame_sink
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned words_got;
        bit          held_long;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        words_got  = 0;
        held_long  = 1'b0;
        frm_bus.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (frm_bus.valid && frm_bus.ready) begin
                words_got++;
                take_word(frm_bus.out_byte, frm_bus.last_byte);
            end
            // long hold-off while requests keep coming, so the frame queue fills
            if (!held_long && words_got >= HOLD_AT_WORD) begin
                held_long = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                frm_bus.ready <= 1'b0;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    stall_left = gap_len();
                    run_left   = $urandom_range(1, 40);
                end
                if (stall_left > 0) begin
                    stall_left--;
                    frm_bus.ready <= 1'b0;
                end else begin
                    run_left--;
                    frm_bus.ready <= 1'b1;
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        #(10_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
